### src/vgsg_pkg.sv
// Shared types, constants, stroke font table and arithmetic helpers of the glyph stroke generator.
package vgsg_pkg;

    localparam int GLYPH_POINTS    = 8;
    localparam int SCALE_FRAC_BITS = 8;

    localparam int ROW_BYTES   = 8;
    localparam int NPTS        = (GLYPH_POINTS < ROW_BYTES) ? GLYPH_POINTS : ROW_BYTES;
    localparam int IDX_W       = $clog2(NPTS + 1);
    localparam int BYTE_IDX_W  = $clog2(ROW_BYTES);
    localparam int SCALE_W     = 12;
    localparam int SY_W        = 13;
    localparam int DX_W        = 4 + SCALE_W;
    localparam int MY_W        = 4 + SY_W;
    localparam int ACC_W       = SCALE_FRAC_BITS + 20;
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] PEN_LIFT    = 8'hFE;
    localparam logic [7:0] GLYPH_END   = 8'hFF;
    localparam logic [7:0] CODE_FIRST  = 8'h20;
    localparam logic [7:0] CODE_LAST   = 8'h7F;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [15:0] RECIP5       = 16'd52429;
    localparam int          RECIP5_SHIFT = 18;
    localparam int          MARGIN       = 4;

    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] ADV_MAX  = ACC_W'(65535);
    localparam logic signed [ACC_W-1:0] ADV_INIT = ACC_W'(-(MARGIN * (1 << SCALE_FRAC_BITS)));
    localparam logic signed [ACC_W-1:0] ORG_BIAS = ACC_W'(MARGIN);

    typedef logic [0:ROW_BYTES-1][7:0] t_row;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LIFT,
        OP_POINT,
        OP_END
    } t_op;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [SCALE_W-1:0] scale;
        logic [SY_W-1:0]    scale_y;
        logic               extents_only;
        logic [31:0]        color;
        t_row               row;
    } t_cmd;

    typedef struct packed {
        logic               seg_valid;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [31:0]        seg_color;
        logic [15:0]        advance;
        logic               last;
    } t_res;

    localparam t_row EMPTY_ROW = '1;

    function automatic t_row glyph_row(input logic [6:0] idx);
        t_row r;
        unique case (idx)
            7'd1:  r = 64'h40_32_52_40_FE_44_4C_FF;
            7'd2:  r = 64'h2A_26_FE_6A_66_FF_FF_FF;
            7'd3:  r = 64'h04_84_62_6A_88_08_2A_22;
            7'd4:  r = 64'h62_26_6A_FE_4C_40_FF_FF;
            7'd5:  r = 64'h00_8C_FE_2A_28_FE_64_62;
            7'd6:  r = 64'h80_4C_88_04_40_84_FF_FF;
            7'd7:  r = 64'h26_6A_FF_FF_FF_FF_FF_FF;
            7'd8:  r = 64'h60_24_28_6C_FF_FF_FF_FF;
            7'd9:  r = 64'h20_64_68_2C_FF_FF_FF_FF;
            7'd10: r = 64'h00_4C_80_08_88_00_FF_FF;
            7'd11: r = 64'h16_76_FE_49_43_FF_FF_FF;
            7'd12: r = 64'h20_42_FF_FF_FF_FF_FF_FF;
            7'd13: r = 64'h26_66_FF_FF_FF_FF_FF_FF;
            7'd14: r = 64'h30_40_FF_FF_FF_FF_FF_FF;
            7'd15: r = 64'h00_8C_FF_FF_FF_FF_FF_FF;
            7'd16: r = 64'h00_80_8C_0C_00_8C_FF_FF;
            7'd17: r = 64'h40_4C_3A_FF_FF_FF_FF_FF;
            7'd18: r = 64'h0C_8C_87_05_00_80_FF_FF;
            7'd19: r = 64'h0C_8C_80_00_FE_06_86_FF;
            7'd20: r = 64'h0C_06_86_FE_8C_80_FF_FF;
            7'd21: r = 64'h00_80_86_07_0C_8C_FF_FF;
            7'd22: r = 64'h0C_00_80_85_07_FF_FF_FF;
            7'd23: r = 64'h0C_8C_86_40_FF_FF_FF_FF;
            7'd24: r = 64'h00_80_8C_0C_00_FE_06_86;
            7'd25: r = 64'h80_8C_0C_07_85_FF_FF_FF;
            7'd26: r = 64'h49_47_FE_45_43_FF_FF_FF;
            7'd27: r = 64'h49_47_FE_45_12_FF_FF_FF;
            7'd28: r = 64'h60_26_6C_FF_FF_FF_FF_FF;
            7'd29: r = 64'h14_74_FE_18_78_FF_FF_FF;
            7'd30: r = 64'h20_66_2C_FF_FF_FF_FF_FF;
            7'd31: r = 64'h08_4C_88_44_FE_41_40_FF;
            7'd32: r = 64'h84_40_04_08_4C_88_44_36;
            7'd33: r = 64'h00_08_4C_88_80_FE_04_84;
            7'd34: r = 64'h00_0C_4C_8A_46_82_40_00;
            7'd35: r = 64'h80_00_0C_8C_FF_FF_FF_FF;
            7'd36: r = 64'h00_0C_4C_88_84_40_00_FF;
            7'd37: r = 64'h80_00_0C_8C_FE_06_66_FF;
            7'd38: r = 64'h00_0C_8C_FE_06_66_FF_FF;
            7'd39: r = 64'h66_84_80_00_0C_8C_FF_FF;
            7'd40: r = 64'h00_0C_FE_06_86_FE_8C_80;
            7'd41: r = 64'h00_80_FE_40_4C_FE_0C_8C;
            7'd42: r = 64'h04_40_80_8C_FF_FF_FF_FF;
            7'd43: r = 64'h00_0C_FE_8C_06_60_FF_FF;
            7'd44: r = 64'h80_00_0C_FF_FF_FF_FF_FF;
            7'd45: r = 64'h00_0C_48_8C_80_FF_FF_FF;
            7'd46: r = 64'h00_0C_80_8C_FF_FF_FF_FF;
            7'd47: r = 64'h00_0C_8C_80_00_FF_FF_FF;
            7'd48: r = 64'h00_0C_8C_86_05_FF_FF_FF;
            7'd49: r = 64'h00_0C_8C_84_00_FE_44_80;
            7'd50: r = 64'h00_0C_8C_86_05_FE_45_80;
            7'd51: r = 64'h02_20_80_85_07_0C_6C_8A;
            7'd52: r = 64'h0C_8C_FE_4C_40_FF_FF_FF;
            7'd53: r = 64'h0C_02_40_82_8C_FF_FF_FF;
            7'd54: r = 64'h0C_40_8C_FF_FF_FF_FF_FF;
            7'd55: r = 64'h0C_20_44_60_8C_FF_FF_FF;
            7'd56: r = 64'h00_8C_FE_0C_80_FF_FF_FF;
            7'd57: r = 64'h0C_46_8C_FE_46_40_FF_FF;
            7'd58: r = 64'h0C_8C_00_80_FE_26_66_FF;
            7'd59: r = 64'h60_20_2C_6C_FF_FF_FF_FF;
            7'd60: r = 64'h0C_80_FF_FF_FF_FF_FF_FF;
            7'd61: r = 64'h20_60_6C_2C_FF_FF_FF_FF;
            7'd62: r = 64'h26_4C_66_FF_FF_FF_FF_FF;
            7'd63: r = 64'h00_80_FF_FF_FF_FF_FF_FF;
            7'd64: r = 64'h2A_66_FF_FF_FF_FF_FF_FF;
            7'd91: r = 64'h60_42_4A_6C_FE_26_46_FF;
            7'd92: r = 64'h40_45_FE_46_4C_FF_FF_FF;
            7'd93: r = 64'h40_62_6A_4C_FE_66_86_FF;
            7'd94: r = 64'h04_28_64_88_FF_FF_FF_FF;
            default: r = EMPTY_ROW;
        endcase
        return r;
    endfunction

    // Divide by the scale unit, rounding toward zero.
    function automatic logic signed [ACC_W-1:0] trunc_shift(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        q = v >>> SCALE_FRAC_BITS;
        if (v[ACC_W-1] && (v[SCALE_FRAC_BITS-1:0] != '0)) begin
            q = q + ACC_W'(1);
        end
        return q;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_HI) begin
            r = 16'sh7FFF;
        end else if (v < SAT_LO) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### src/vgsg_front.sv
// Front end: folds case, picks the stroke row and derives the vertical scale of a request.
module vgsg_front import vgsg_pkg::*; (
    input  logic               i_push,
    input  logic               i_full,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic [7:0]         i_char_code,
    input  logic [SCALE_W-1:0] i_scale,
    input  logic               i_extents_only,
    input  logic [31:0]        i_color,
    output logic               o_wr,
    output t_cmd               o_cmd
);

    logic                  lower;
    logic [7:0]            code_up;
    logic                  in_table;
    logic [6:0]            row_idx;
    logic [14:0]           scale5;
    logic [13:0]           scale4;
    logic [29:0]           recip_prod;
    logic [SY_W-1:0]       sy_up;
    logic [SY_W-1:0]       sy_low;

    always_comb begin
        lower      = (i_char_code >= LOWER_A) && (i_char_code <= LOWER_Z);
        code_up    = lower ? (i_char_code - CASE_OFFSET) : i_char_code;
        in_table   = (code_up >= CODE_FIRST) && (code_up <= CODE_LAST);
        row_idx    = 7'(code_up - CODE_FIRST);
        scale5     = 15'(i_scale) * 15'd5;
        sy_up      = scale5[14:2];
        scale4     = {i_scale, 2'b00};
        recip_prod = 30'(scale4) * 30'(RECIP5);
        sy_low     = SY_W'(recip_prod[29:RECIP5_SHIFT]);
    end

    always_comb begin
        o_wr                 = i_push && !i_full;
        o_cmd.origin_x       = i_origin_x;
        o_cmd.origin_y       = i_origin_y;
        o_cmd.scale          = i_scale;
        o_cmd.scale_y        = lower ? sy_low : sy_up;
        o_cmd.extents_only   = i_extents_only;
        o_cmd.color          = i_color;
        o_cmd.row            = in_table ? glyph_row(row_idx) : EMPTY_ROW;
    end

endmodule

### src/vgsg_cmd_fifo.sv
// Short command queue between the front end and the stroke walker.
module vgsg_cmd_fifo import vgsg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr;
    logic [CMD_PTR_W-1:0] r_rd;
    logic [CMD_CNT_W-1:0] r_count;
    logic [CMD_PTR_W-1:0] n_wr;
    logic [CMD_PTR_W-1:0] n_rd;
    logic [CMD_CNT_W-1:0] n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr + CMD_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd + CMD_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CMD_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### src/vgsg_back.sv
// Back end: three-stage datapath that walks the stroke row one point a cycle unless the result queue is full.
module vgsg_back import vgsg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_empty,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    logic                    r_busy;
    logic                    r_issue_done;
    logic [IDX_W-1:0]        r_idx;
    t_cmd                    r_cmd;
    logic signed [ACC_W-1:0] r_adv;
    logic                    r_down;
    logic signed [15:0]      r_pen_x;
    logic signed [15:0]      r_pen_y;
    logic                    r_pend_v;
    t_res                    r_pend;

    t_op                     r_op1;
    logic [3:0]              r_nx1;
    logic [3:0]              r_ny1;
    t_op                     r_op2;
    logic [DX_W-1:0]         r_dx2;
    logic [MY_W-1:0]         r_my2;
    t_op                     r_op3;
    logic signed [15:0]      r_px3;
    logic signed [ACC_W-1:0] r_k3;

    logic [7:0]              cur_byte;
    logic                    issue_en;
    t_op                     op0;
    logic [DX_W-1:0]         dx1;
    logic [MY_W-1:0]         my1;
    logic signed [ACC_W-1:0] ox_acc;
    logic signed [ACC_W-1:0] oy_acc;
    logic signed [ACC_W-1:0] dx_acc;
    logic signed [ACC_W-1:0] four_s;
    logic signed [ACC_W-1:0] x_acc;
    logic signed [ACC_W-1:0] y_acc;
    logic signed [15:0]      px2;
    logic signed [ACC_W-1:0] k2;
    logic signed [ACC_W-1:0] em_acc;
    logic signed [ACC_W-1:0] py_acc;
    logic signed [15:0]      py3;
    logic signed [ACC_W-1:0] adv_f;
    logic signed [ACC_W-1:0] adv_q;
    logic [15:0]             advance;
    logic                    new_seg;
    logic                    push_need;
    logic                    stall;
    logic                    load;

    always_comb begin
        cur_byte = r_cmd.row[r_idx[BYTE_IDX_W-1:0]];
        issue_en = r_busy && !r_issue_done;
        if ((r_idx == IDX_W'(NPTS)) || (cur_byte == GLYPH_END)) begin
            op0 = OP_END;
        end else if (cur_byte == PEN_LIFT) begin
            op0 = OP_LIFT;
        end else begin
            op0 = OP_POINT;
        end
    end

    always_comb begin
        dx1 = DX_W'(r_nx1) * DX_W'(r_cmd.scale);
        my1 = MY_W'(r_ny1) * MY_W'(r_cmd.scale_y);
    end

    always_comb begin
        ox_acc = ACC_W'(r_cmd.origin_x) + ORG_BIAS;
        oy_acc = ACC_W'(r_cmd.origin_y) + ORG_BIAS;
        dx_acc = $signed(ACC_W'(r_dx2));
        four_s = $signed(ACC_W'({r_cmd.scale, 2'b00}));
        x_acc  = (ox_acc <<< SCALE_FRAC_BITS) + dx_acc;
        y_acc  = (oy_acc <<< SCALE_FRAC_BITS) - $signed(ACC_W'(r_my2));
        px2    = sat16(trunc_shift(x_acc));
        k2     = trunc_shift(y_acc);
    end

    always_comb begin
        em_acc    = $signed(ACC_W'({r_cmd.scale, 3'b000}) + ACC_W'({r_cmd.scale, 2'b00}));
        py_acc    = (r_k3 <<< SCALE_FRAC_BITS) + em_acc;
        py3       = sat16(trunc_shift(py_acc));
        adv_f     = (r_adv < em_acc) ? em_acc : r_adv;
        adv_q     = adv_f >>> SCALE_FRAC_BITS;
        advance   = (adv_q > ADV_MAX) ? 16'hFFFF : adv_q[15:0];
        new_seg   = (r_op3 == OP_POINT) && r_down && !r_cmd.extents_only;
        push_need = (new_seg && r_pend_v) || (r_op3 == OP_END);
        stall     = push_need && i_res_full;
        load      = !r_busy && !i_cmd_empty;
    end

    always_comb begin
        o_res_push = push_need && !i_res_full;
        o_cmd_pop  = load;
        o_res      = r_pend;
        if (r_op3 == OP_END) begin
            if (r_pend_v) begin
                o_res.advance = advance;
                o_res.last    = 1'b1;
            end else begin
                o_res         = '0;
                o_res.advance = advance;
                o_res.last    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_issue_done <= 1'b0;
            r_idx        <= '0;
            r_down       <= 1'b0;
            r_pend_v     <= 1'b0;
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_op1        <= OP_NONE;
            r_op2        <= OP_NONE;
            r_op3        <= OP_NONE;
        end else if (load) begin
            r_busy       <= 1'b1;
            r_issue_done <= 1'b0;
            r_idx        <= '0;
            r_down       <= 1'b0;
            r_pend_v     <= 1'b0;
        end else if (!stall) begin
            r_op1 <= issue_en ? op0 : OP_NONE;
            r_op2 <= r_op1;
            r_op3 <= r_op2;
            if (issue_en) begin
                r_idx <= r_idx + IDX_W'(1);
                if (op0 == OP_END) begin
                    r_issue_done <= 1'b1;
                end
            end
            case (r_op3)
                OP_POINT: begin
                    r_pen_x <= r_px3;
                    r_pen_y <= py3;
                    r_down  <= 1'b1;
                    if (new_seg) begin
                        r_pend_v <= 1'b1;
                    end
                end
                OP_LIFT: begin
                    r_down <= 1'b0;
                end
                OP_END: begin
                    r_pend_v <= 1'b0;
                    r_busy   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
            r_adv <= ADV_INIT;
        end else if (!stall) begin
            r_nx1 <= cur_byte[7:4];
            r_ny1 <= cur_byte[3:0];
            r_dx2 <= dx1;
            r_my2 <= my1;
            r_px3 <= px2;
            r_k3  <= k2;
            if ((r_op2 == OP_POINT) && (dx_acc > r_adv)) begin
                r_adv <= dx_acc + four_s;
            end
            if (new_seg) begin
                r_pend.seg_valid <= 1'b1;
                r_pend.start_x   <= r_pen_x;
                r_pend.start_y   <= r_pen_y;
                r_pend.end_x     <= r_px3;
                r_pend.end_y     <= py3;
                r_pend.seg_color <= r_cmd.color;
                r_pend.advance   <= '0;
                r_pend.last      <= 1'b0;
            end
        end
    end

endmodule

### src/vgsg_res_fifo.sv
// Result queue that presents the oldest waiting result to the consumer.
module vgsg_res_fifo import vgsg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    input  logic i_pop,
    output t_res o_res,
    output logic o_empty
);

    t_res                 r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr;
    logic [RES_PTR_W-1:0] r_rd;
    logic [RES_CNT_W-1:0] r_count;
    logic [RES_PTR_W-1:0] n_wr;
    logic [RES_PTR_W-1:0] n_rd;
    logic [RES_CNT_W-1:0] n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == RES_CNT_W'(RES_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_res   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_wr + RES_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_rd + RES_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + RES_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

### src/vector_glyph_stroke_generator_top.sv
// Top level of the vector glyph stroke generator.
// Each request draws one character as line segments from a fixed stroke font and ends with a
// result marked last that carries the advance. The stroke walker reads at most 8 font bytes
// per character, one point per cycle while the result queue is not full, and each point
// passes a three-stage datapath. Two requests can wait in the command queue and four
// results in the result queue.
module vector_glyph_stroke_generator_top import vgsg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic [7:0]         i_char_code,
    input  logic [11:0]        i_scale,
    input  logic               i_extents_only,
    input  logic [31:0]        i_color,
    output logic               empty,
    input  logic               pop,
    output logic               o_seg_valid,
    output logic signed [15:0] o_start_x,
    output logic signed [15:0] o_start_y,
    output logic signed [15:0] o_end_x,
    output logic signed [15:0] o_end_y,
    output logic [31:0]        o_seg_color,
    output logic [15:0]        o_advance,
    output logic               o_last
);

    logic front_wr;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_empty;
    logic q_pop;
    logic res_push;
    logic res_full;
    t_res back_res;
    t_res head_res;

    vgsg_front u_front (
        .i_push         (push),
        .i_full         (full),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_char_code    (i_char_code),
        .i_scale        (i_scale),
        .i_extents_only (i_extents_only),
        .i_color        (i_color),
        .o_wr           (front_wr),
        .o_cmd          (front_cmd)
    );

    vgsg_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_wr),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    vgsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    vgsg_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_res   (head_res),
        .o_empty (empty)
    );

    assign o_seg_valid = head_res.seg_valid;
    assign o_start_x   = head_res.start_x;
    assign o_start_y   = head_res.start_y;
    assign o_end_x     = head_res.end_x;
    assign o_end_y     = head_res.end_y;
    assign o_seg_color = head_res.seg_color;
    assign o_advance   = head_res.advance;
    assign o_last      = head_res.last;

endmodule

### dv/vector_glyph_stroke_generator_top_tb.sv
// Self-checking testbench for the vector glyph stroke generator, with a built-in stroke predictor.
`timescale 1ns / 100ps

module vector_glyph_stroke_generator_top_tb import vgsg_pkg::*;;

    localparam longint UNIT         = longint'(1) << SCALE_FRAC_BITS;
    localparam int     RANDOM_ITEMS = 98;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     HOLD_AFTER   = 30;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 200000;

    typedef struct {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [7:0]         char_code;
        logic [11:0]        scale;
        logic               extents_only;
        logic [31:0]        color;
    } t_glyph_req;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] i_origin_x = '0;
    logic signed [15:0] i_origin_y = '0;
    logic [7:0]         i_char_code = '0;
    logic [11:0]        i_scale = '0;
    logic               i_extents_only = 1'b0;
    logic [31:0]        i_color = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_seg_valid;
    logic signed [15:0] o_start_x;
    logic signed [15:0] o_start_y;
    logic signed [15:0] o_end_x;
    logic signed [15:0] o_end_y;
    logic [31:0]        o_seg_color;
    logic [15:0]        o_advance;
    logic               o_last;

    logic [63:0]        stroke_font [0:95];
    logic signed [15:0] pen_x = '0;
    logic signed [15:0] pen_y = '0;

    t_glyph_req  glyph_queue[$];
    t_res        expected_strokes[$];
    int          mismatches = 0;
    int          requests_taken = 0;
    int          cycle_count = 0;
    bit          req_accepted = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    vector_glyph_stroke_generator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_char_code    (i_char_code),
        .i_scale        (i_scale),
        .i_extents_only (i_extents_only),
        .i_color        (i_color),
        .empty          (empty),
        .pop            (pop),
        .o_seg_valid    (o_seg_valid),
        .o_start_x      (o_start_x),
        .o_start_y      (o_start_y),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_seg_color    (o_seg_color),
        .o_advance      (o_advance),
        .o_last         (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    task automatic draw_glyph(input t_glyph_req g);
        longint      s, sy, ox, oy, nx, ny, dx, adv, k, px, py;
        logic [7:0]  code, b;
        logic [63:0] strokes;
        bit          down;
        int          segs;
        t_res        r;
        s = g.scale;
        ox = g.origin_x;
        oy = g.origin_y;
        sy = (s * 5) / 4;
        adv = -4 * UNIT;
        down = 0;
        segs = 0;
        code = g.char_code;
        if (code >= LOWER_A && code <= LOWER_Z) begin
            code = code - CASE_OFFSET;
            sy = (s * 4) / 5;
        end
        strokes = (code >= CODE_FIRST && code <= CODE_LAST) ? stroke_font[code - CODE_FIRST]
                                                            : '1;
        for (int i = 0; i < NPTS; i++) begin
            b = strokes[63 - 8 * i -: 8];
            if (b == GLYPH_END) begin
                break;
            end
            if (b == PEN_LIFT) begin
                down = 0;
                continue;
            end
            nx = b[7:4];
            ny = b[3:0];
            dx = nx * s;
            if (dx > adv) begin
                adv = dx + 4 * s;
            end
            px = clip16(((ox + 4) * UNIT + dx) / UNIT);
            k = ((oy + 4) * UNIT - ny * sy) / UNIT;
            py = clip16((k * UNIT + 12 * s) / UNIT);
            if (down && !g.extents_only && segs < 7) begin
                r.seg_valid = 1'b1;
                r.start_x = pen_x;
                r.start_y = pen_y;
                r.end_x = px[15:0];
                r.end_y = py[15:0];
                r.seg_color = g.color;
                r.advance = '0;
                r.last = 1'b0;
                expected_strokes.push_back(r);
                segs++;
            end
            pen_x = px[15:0];
            pen_y = py[15:0];
            down = 1;
        end
        if (adv < 12 * s) begin
            adv = 12 * s;
        end
        adv = adv / UNIT;
        if (adv > 65535) begin
            adv = 65535;
        end
        if (segs == 0) begin
            r = '0;
            r.advance = adv[15:0];
            r.last = 1'b1;
            expected_strokes.push_back(r);
        end else begin
            expected_strokes[expected_strokes.size() - 1].advance = adv[15:0];
            expected_strokes[expected_strokes.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_glyph(input logic signed [15:0] ox, input logic signed [15:0] oy,
                             input logic [7:0] code, input logic [11:0] s,
                             input logic ext, input logic [31:0] color);
        t_glyph_req g;
        g.origin_x = ox;
        g.origin_y = oy;
        g.char_code = code;
        g.scale = s;
        g.extents_only = ext;
        g.color = color;
        glyph_queue.push_back(g);
    endtask

    function automatic t_glyph_req random_glyph();
        t_glyph_req g;
        g.char_code = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(8'h20, 8'h7E))
                                                 : 8'($urandom_range(0, 255));
        g.scale = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(64, 768));
        g.origin_x = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                 : 16'($urandom_range(0, 2000)) - 16'sd1000;
        g.origin_y = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                 : 16'($urandom_range(0, 2000)) - 16'sd1000;
        g.extents_only = ($urandom_range(0, 7) == 0);
        g.color = $urandom();
        return g;
    endfunction

    // Request and result side checks, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_res want;
        t_glyph_req g;
        cycle_count++;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_strokes.size() == 0) begin
                    $error("Result arrived with no stroke expected.");
                    mismatches++;
                end else begin
                    want = expected_strokes.pop_front();
                    check_field("seg_valid", want.seg_valid, o_seg_valid);
                    check_field("start_x", want.start_x, o_start_x);
                    check_field("start_y", want.start_y, o_start_y);
                    check_field("end_x", want.end_x, o_end_x);
                    check_field("end_y", want.end_y, o_end_y);
                    check_field("seg_color", want.seg_color, o_seg_color);
                    check_field("advance", want.advance, o_advance);
                    check_field("last", want.last, o_last);
                end
            end
            if (push && !full) begin
                g.origin_x = i_origin_x;
                g.origin_y = i_origin_y;
                g.char_code = i_char_code;
                g.scale = i_scale;
                g.extents_only = i_extents_only;
                g.color = i_color;
                draw_glyph(g);
                requests_taken++;
                req_accepted = 1;
            end
        end
    end

    // Sender: bursts of requests separated by random gaps.
    always @(negedge i_clk) begin
        bit hold;
        if (i_rst_n) begin
            hold = push && !req_accepted;
            if (req_accepted) begin
                void'(glyph_queue.pop_front());
                req_accepted = 0;
            end
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (glyph_queue.size() > 0) begin
                    i_origin_x <= glyph_queue[0].origin_x;
                    i_origin_y <= glyph_queue[0].origin_y;
                    i_char_code <= glyph_queue[0].char_code;
                    i_scale <= glyph_queue[0].scale;
                    i_extents_only <= glyph_queue[0].extents_only;
                    i_color <= glyph_queue[0].color;
                    push <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: changing stall patterns and one long hold-off to back the block up.
    always @(negedge i_clk) begin
        bit take;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                take = 0;
            end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                take = 0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(1, 40);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE: begin
                        take = 1;
                    end
                    STALL_HALF: begin
                        take = $urandom_range(0, 1);
                    end
                    default: begin
                        take = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
            pop <= take;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        foreach (stroke_font[i]) stroke_font[i] = '1;
        stroke_font[1]  = 64'h40_32_52_40_FE_44_4C_FF;
        stroke_font[2]  = 64'h2A_26_FE_6A_66_FF_FF_FF;
        stroke_font[3]  = 64'h04_84_62_6A_88_08_2A_22;
        stroke_font[4]  = 64'h62_26_6A_FE_4C_40_FF_FF;
        stroke_font[5]  = 64'h00_8C_FE_2A_28_FE_64_62;
        stroke_font[6]  = 64'h80_4C_88_04_40_84_FF_FF;
        stroke_font[7]  = 64'h26_6A_FF_FF_FF_FF_FF_FF;
        stroke_font[8]  = 64'h60_24_28_6C_FF_FF_FF_FF;
        stroke_font[9]  = 64'h20_64_68_2C_FF_FF_FF_FF;
        stroke_font[10] = 64'h00_4C_80_08_88_00_FF_FF;
        stroke_font[11] = 64'h16_76_FE_49_43_FF_FF_FF;
        stroke_font[12] = 64'h20_42_FF_FF_FF_FF_FF_FF;
        stroke_font[13] = 64'h26_66_FF_FF_FF_FF_FF_FF;
        stroke_font[14] = 64'h30_40_FF_FF_FF_FF_FF_FF;
        stroke_font[15] = 64'h00_8C_FF_FF_FF_FF_FF_FF;
        stroke_font[16] = 64'h00_80_8C_0C_00_8C_FF_FF;
        stroke_font[17] = 64'h40_4C_3A_FF_FF_FF_FF_FF;
        stroke_font[18] = 64'h0C_8C_87_05_00_80_FF_FF;
        stroke_font[19] = 64'h0C_8C_80_00_FE_06_86_FF;
        stroke_font[20] = 64'h0C_06_86_FE_8C_80_FF_FF;
        stroke_font[21] = 64'h00_80_86_07_0C_8C_FF_FF;
        stroke_font[22] = 64'h0C_00_80_85_07_FF_FF_FF;
        stroke_font[23] = 64'h0C_8C_86_40_FF_FF_FF_FF;
        stroke_font[24] = 64'h00_80_8C_0C_00_FE_06_86;
        stroke_font[25] = 64'h80_8C_0C_07_85_FF_FF_FF;
        stroke_font[26] = 64'h49_47_FE_45_43_FF_FF_FF;
        stroke_font[27] = 64'h49_47_FE_45_12_FF_FF_FF;
        stroke_font[28] = 64'h60_26_6C_FF_FF_FF_FF_FF;
        stroke_font[29] = 64'h14_74_FE_18_78_FF_FF_FF;
        stroke_font[30] = 64'h20_66_2C_FF_FF_FF_FF_FF;
        stroke_font[31] = 64'h08_4C_88_44_FE_41_40_FF;
        stroke_font[32] = 64'h84_40_04_08_4C_88_44_36;
        stroke_font[33] = 64'h00_08_4C_88_80_FE_04_84;
        stroke_font[34] = 64'h00_0C_4C_8A_46_82_40_00;
        stroke_font[35] = 64'h80_00_0C_8C_FF_FF_FF_FF;
        stroke_font[36] = 64'h00_0C_4C_88_84_40_00_FF;
        stroke_font[37] = 64'h80_00_0C_8C_FE_06_66_FF;
        stroke_font[38] = 64'h00_0C_8C_FE_06_66_FF_FF;
        stroke_font[39] = 64'h66_84_80_00_0C_8C_FF_FF;
        stroke_font[40] = 64'h00_0C_FE_06_86_FE_8C_80;
        stroke_font[41] = 64'h00_80_FE_40_4C_FE_0C_8C;
        stroke_font[42] = 64'h04_40_80_8C_FF_FF_FF_FF;
        stroke_font[43] = 64'h00_0C_FE_8C_06_60_FF_FF;
        stroke_font[44] = 64'h80_00_0C_FF_FF_FF_FF_FF;
        stroke_font[45] = 64'h00_0C_48_8C_80_FF_FF_FF;
        stroke_font[46] = 64'h00_0C_80_8C_FF_FF_FF_FF;
        stroke_font[47] = 64'h00_0C_8C_80_00_FF_FF_FF;
        stroke_font[48] = 64'h00_0C_8C_86_05_FF_FF_FF;
        stroke_font[49] = 64'h00_0C_8C_84_00_FE_44_80;
        stroke_font[50] = 64'h00_0C_8C_86_05_FE_45_80;
        stroke_font[51] = 64'h02_20_80_85_07_0C_6C_8A;
        stroke_font[52] = 64'h0C_8C_FE_4C_40_FF_FF_FF;
        stroke_font[53] = 64'h0C_02_40_82_8C_FF_FF_FF;
        stroke_font[54] = 64'h0C_40_8C_FF_FF_FF_FF_FF;
        stroke_font[55] = 64'h0C_20_44_60_8C_FF_FF_FF;
        stroke_font[56] = 64'h00_8C_FE_0C_80_FF_FF_FF;
        stroke_font[57] = 64'h0C_46_8C_FE_46_40_FF_FF;
        stroke_font[58] = 64'h0C_8C_00_80_FE_26_66_FF;
        stroke_font[59] = 64'h60_20_2C_6C_FF_FF_FF_FF;
        stroke_font[60] = 64'h0C_80_FF_FF_FF_FF_FF_FF;
        stroke_font[61] = 64'h20_60_6C_2C_FF_FF_FF_FF;
        stroke_font[62] = 64'h26_4C_66_FF_FF_FF_FF_FF;
        stroke_font[63] = 64'h00_80_FF_FF_FF_FF_FF_FF;
        stroke_font[64] = 64'h2A_66_FF_FF_FF_FF_FF_FF;
        stroke_font[91] = 64'h60_42_4A_6C_FE_26_46_FF;
        stroke_font[92] = 64'h40_45_FE_46_4C_FF_FF_FF;
        stroke_font[93] = 64'h40_62_6A_4C_FE_66_86_FF;
        stroke_font[94] = 64'h04_28_64_88_FF_FF_FF_FF;

        // Directed requests: field extremes, saturation, case folding and empty glyphs.
        add_glyph(16'sd0, 16'sd0, "A", 12'd256, 1'b0, 32'hFFFF_FFFF);
        add_glyph(16'sh7FFF, 16'sh7FFF, "@", 12'hFFF, 1'b0, 32'h0000_0000);
        add_glyph(16'sh8000, 16'sh8000, "H", 12'hFFF, 1'b0, 32'hA5A5_5A5A);
        add_glyph(16'sd100, -16'sd50, "a", 12'd256, 1'b0, 32'h1234_5678);
        add_glyph(-16'sd300, 16'sd200, "z", 12'hFFF, 1'b0, 32'h8000_0001);
        add_glyph(16'sd10, 16'sd10, 8'h60, 12'd300, 1'b0, 32'hDEAD_BEEF);
        add_glyph(16'sd20, 16'sd20, 8'h7B, 12'd512, 1'b0, 32'h0F0F_0F0F);
        add_glyph(16'sd0, 16'sd0, "~", 12'd128, 1'b0, 32'hF0F0_F0F0);
        add_glyph(16'sd5, 16'sd5, 8'h7F, 12'd256, 1'b0, 32'h1111_1111);
        add_glyph(16'sd5, 16'sd5, 8'h00, 12'hFFF, 1'b0, 32'h2222_2222);
        add_glyph(16'sd5, 16'sd5, 8'h1F, 12'd256, 1'b0, 32'h3333_3333);
        add_glyph(16'sd5, 16'sd5, 8'h80, 12'd256, 1'b0, 32'h4444_4444);
        add_glyph(16'sd5, 16'sd5, 8'hFF, 12'd1, 1'b0, 32'h5555_5555);
        add_glyph(16'sd0, 16'sd0, " ", 12'd256, 1'b0, 32'h6666_6666);
        add_glyph(16'sd40, 16'sd40, "#", 12'd256, 1'b1, 32'h7777_7777);
        add_glyph(16'sd40, 16'sd40, "B", 12'd0, 1'b0, 32'h8888_8888);
        add_glyph(-16'sd1, -16'sd1, "8", 12'd384, 1'b0, 32'h0000_0000);
        add_glyph(16'sd7, -16'sd7, "!", 12'd1, 1'b0, 32'hFFFF_FFFF);
        add_glyph(16'sd1000, 16'sd1000, "%", 12'd700, 1'b0, 32'hCAFE_F00D);
        add_glyph(16'sd50, 16'sd60, "w", 12'd999, 1'b1, 32'h0BAD_CAFE);
        add_glyph(16'sh8000, 16'sh7FFF, "S", 12'hFFF, 1'b0, 32'h5A5A_A5A5);
        add_glyph(16'sh7FFF, 16'sh8000, "Q", 12'd2048, 1'b0, 32'h0123_4567);
        repeat (RANDOM_ITEMS) glyph_queue.push_back(random_glyph());

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (glyph_queue.size() != 0 || expected_strokes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_strokes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
